/* rtl/assert_macros.svh */
// assertion helpers, compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define UQD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

`define UQD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define UQD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define UQD_ASSERT(lbl, clk, rst_n, prop)
`define UQD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define UQD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/uqd_pkg.sv */
package uqd_pkg;

  localparam logic [7:0] ChPercent  = 8'h25;
  localparam logic [7:0] ChQuestion = 8'h3F;
  localparam logic [7:0] ChEquals   = 8'h3D;
  localparam logic [7:0] ChAmp      = 8'h26;
  localparam logic [7:0] ChZero     = 8'h30;
  localparam logic [7:0] ChNine     = 8'h39;
  localparam logic [7:0] ChLowA     = 8'h61;
  localparam logic [7:0] ChLowF     = 8'h66;
  localparam logic [7:0] ChUpA      = 8'h41;
  localparam logic [7:0] ChUpF      = 8'h46;

  typedef enum logic [1:0] {
    PH_PATH  = 2'd0,
    PH_NAME  = 2'd1,
    PH_VALUE = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ESC_NONE   = 2'd0,
    ESC_FIRST  = 2'd1,
    ESC_SECOND = 2'd2
  } esc_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] decoded_byte;
    logic [1:0] token_kind;
    logic       token_end;
    logic       target_done;
    logic       parse_error;
  } out_item_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] nibble;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    logic [7:0] t;
    h = '{bad: 1'b1, nibble: 4'd0};
    t = 8'd0;
    if (c >= ChZero && c <= ChNine) begin
      t = c - ChZero;
      h = '{bad: 1'b0, nibble: t[3:0]};
    end else if (c >= ChLowA && c <= ChLowF) begin
      t = c - ChLowA + 8'd10;
      h = '{bad: 1'b0, nibble: t[3:0]};
    end else if (c >= ChUpA && c <= ChUpF) begin
      t = c - ChUpA + 8'd10;
      h = '{bad: 1'b0, nibble: t[3:0]};
    end
    return h;
  endfunction

endpackage

/* rtl/url_path_query_decoder.sv */
// url target decoder: one raw byte in, one result out per transfer
// a result is registered in out_q, or held in the skid entry while the output is stalled
// throughput: one byte per cycle while the skid entry is empty (in_stall_o low), set by the single decode stage
// a two-entry output buffer (result register plus skid) keeps input open under one stall
// reset clears parse state, sticky error and the valid flags of both output entries
`include "assert_macros.svh"

module url_path_query_decoder import uqd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  phase_e     phase_q, phase_d;
  esc_e       esc_q, esc_d;
  logic [3:0] nib_q, nib_d;
  logic       err_q, err_d;

  out_item_t  res;
  out_item_t  out_q, skid_q;
  logic       out_valid_q, skid_valid_q;
  logic       accept;
  hex_t       hx;

  assign accept     = in_valid_i && !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  always_comb begin
    phase_d          = phase_q;
    esc_d            = esc_q;
    nib_d            = nib_q;
    err_d            = err_q;
    hx               = hex_digit(in_data_i.in_byte);
    res.byte_valid   = 1'b0;
    res.decoded_byte = 8'd0;
    res.token_kind   = phase_q;
    res.token_end    = 1'b0;
    res.target_done  = 1'b0;
    res.parse_error  = 1'b0;

    if (esc_q == ESC_FIRST) begin
      if (hx.bad) begin
        err_d = 1'b1;
        esc_d = ESC_NONE;
      end else begin
        nib_d = hx.nibble;
        esc_d = ESC_SECOND;
      end
    end else if (esc_q == ESC_SECOND) begin
      if (hx.bad) begin
        err_d = 1'b1;
      end else begin
        res.decoded_byte = {nib_q, hx.nibble};
        res.byte_valid   = 1'b1;
      end
      esc_d = ESC_NONE;
    end else if (in_data_i.in_byte == ChPercent) begin
      esc_d = ESC_FIRST;
    end else if (phase_q == PH_PATH && in_data_i.in_byte == ChQuestion) begin
      res.token_end = 1'b1;
      phase_d       = PH_NAME;
    end else if (phase_q == PH_NAME && in_data_i.in_byte == ChEquals) begin
      res.token_end = 1'b1;
      phase_d       = PH_VALUE;
    end else if (phase_q == PH_VALUE && in_data_i.in_byte == ChAmp) begin
      res.token_end = 1'b1;
      phase_d       = PH_NAME;
    end else begin
      res.byte_valid   = 1'b1;
      res.decoded_byte = in_data_i.in_byte;
    end

    if (in_data_i.in_last) begin
      // cut-off escape or a name with no '=' (covers trailing '?' and '&')
      if (esc_d != ESC_NONE || phase_d == PH_NAME) begin
        err_d = 1'b1;
      end
      res.token_end   = 1'b1;
      res.target_done = 1'b1;
    end
    res.parse_error = err_d;

    if (in_data_i.in_last) begin
      phase_d = PH_PATH;
      esc_d   = ESC_NONE;
      nib_d   = 4'd0;
      err_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PATH;
      esc_q   <= ESC_NONE;
      nib_q   <= 4'd0;
      err_q   <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      esc_q   <= esc_d;
      nib_q   <= nib_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `UQD_ASSERT_IMPLY(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q)
  `UQD_ASSERT_IMPLY(a_no_byte_zero, clk_i, rst_ni,
                    out_valid_q && !out_q.byte_valid, out_q.decoded_byte == 8'd0)
  `UQD_ASSERT_NEXT(a_last_resets, clk_i, rst_ni, accept && in_data_i.in_last,
                   phase_q == PH_PATH && esc_q == ESC_NONE && !err_q)
  `UQD_ASSERT_IMPLY(a_done_ends_token, clk_i, rst_ni,
                    out_valid_q && out_q.target_done, out_q.token_end)

endmodule

/* test/testbench.sv */
module testbench;
  import uqd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] byte_list_t [$];

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  url_path_query_decoder DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // decoder state as the block should hold it
  phase_e     cur_phase = PH_PATH;
  esc_e       esc_state = ESC_NONE;
  logic [3:0] hi_nibble = 4'd0;
  logic       err_flag = 1'b0;
  logic       opened_pair = 1'b0;

  out_item_t  decoded_queue [$];
  int         mismatches = 0;
  int         bytes_sent = 0;
  bit         idling_on = 1'b1;
  int         stall_left = 0;
  byte_list_t target_buf;

  // {bad, nibble}
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= ChZero && c <= ChNine) begin
      d = c - ChZero;
      return {1'b0, d[3:0]};
    end
    if (c >= ChLowA && c <= ChLowF) begin
      d = c - ChLowA + 8'd10;
      return {1'b0, d[3:0]};
    end
    if (c >= ChUpA && c <= ChUpF) begin
      d = c - ChUpA + 8'd10;
      return {1'b0, d[3:0]};
    end
    return 5'h10;
  endfunction

  function automatic out_item_t decode_byte(input logic [7:0] b, input logic is_last);
    out_item_t  r;
    logic [4:0] h;
    r = '0;
    r.token_kind = cur_phase;
    opened_pair = 1'b0;
    h = hex_nibble(b);
    if (esc_state == ESC_FIRST) begin
      if (h[4]) begin
        err_flag = 1'b1;
        esc_state = ESC_NONE;
      end else begin
        hi_nibble = h[3:0];
        esc_state = ESC_SECOND;
      end
    end else if (esc_state == ESC_SECOND) begin
      if (h[4]) begin
        err_flag = 1'b1;
      end else begin
        r.decoded_byte = {hi_nibble, h[3:0]};
        r.byte_valid = 1'b1;
      end
      esc_state = ESC_NONE;
    end else if (b == ChPercent) begin
      esc_state = ESC_FIRST;
    end else if (cur_phase == PH_PATH && b == ChQuestion) begin
      r.token_end = 1'b1;
      cur_phase = PH_NAME;
      opened_pair = 1'b1;
    end else if (cur_phase == PH_NAME && b == ChEquals) begin
      r.token_end = 1'b1;
      cur_phase = PH_VALUE;
    end else if (cur_phase == PH_VALUE && b == ChAmp) begin
      r.token_end = 1'b1;
      cur_phase = PH_NAME;
      opened_pair = 1'b1;
    end else begin
      r.byte_valid = 1'b1;
      r.decoded_byte = b;
    end
    if (is_last) begin
      if (esc_state != ESC_NONE || opened_pair || cur_phase == PH_NAME) err_flag = 1'b1;
      r.token_end = 1'b1;
      r.target_done = 1'b1;
    end
    r.parse_error = err_flag;
    if (is_last) begin
      cur_phase = PH_PATH;
      esc_state = ESC_NONE;
      hi_nibble = 4'd0;
      err_flag = 1'b0;
      opened_pair = 1'b0;
    end
    return r;
  endfunction

  function automatic int idle_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  function automatic int sender_gap();
    if (!idling_on || $urandom_range(0, 99) < 65) return 0;
    return idle_len();
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int gap;
    gap = sender_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= '{in_byte: b, in_last: is_last};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    decoded_queue.push_back(decode_byte(b, is_last));
    bytes_sent++;
  endtask

  task automatic send_target(input byte_list_t t);
    foreach (t[i]) send_byte(t[i], i == t.size() - 1);
  endtask

  // random receiver stalls
  always @(negedge clk_i) begin
    if (stall_left == 0 && idling_on && $urandom_range(0, 9) < 3) stall_left = idle_len();
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic void check_field(input string what, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, actual %0h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (decoded_queue.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, out_data_o);
        mismatches++;
      end else begin
        want = decoded_queue.pop_front();
        check_field("byte_valid", 8'(want.byte_valid), 8'(out_data_o.byte_valid));
        check_field("decoded_byte", want.decoded_byte, out_data_o.decoded_byte);
        check_field("token_kind", 8'(want.token_kind), 8'(out_data_o.token_kind));
        check_field("token_end", 8'(want.token_end), 8'(out_data_o.token_end));
        check_field("target_done", 8'(want.target_done), 8'(out_data_o.target_done));
        check_field("parse_error", 8'(want.parse_error), 8'(out_data_o.parse_error));
      end
    end
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return ChZero + n;
    return ($urandom_range(0, 1) ? ChUpA : ChLowA) + n - 8'd10;
  endfunction

  // random token body; stop is the separator that would end it
  task automatic append_token(input logic [7:0] stop);
    int         len;
    logic [7:0] c;
    len = $urandom_range(0, 5);
    repeat (len) begin
      if ($urandom_range(0, 9) < 3) begin
        target_buf.push_back(ChPercent);
        target_buf.push_back(hex_char(4'($urandom_range(0, 15))));
        target_buf.push_back(hex_char(4'($urandom_range(0, 15))));
      end else begin
        do c = 8'($urandom_range(0, 255)); while (c == ChPercent || c == stop);
        target_buf.push_back(c);
      end
    end
  endtask

  task automatic build_good_target();
    int pairs;
    target_buf.delete();
    append_token(ChQuestion);
    pairs = $urandom_range(0, 3);
    for (int p = 0; p < pairs; p++) begin
      target_buf.push_back(p == 0 ? ChQuestion : ChAmp);
      append_token(ChEquals);
      target_buf.push_back(ChEquals);
      append_token(ChAmp);
    end
    if (target_buf.size() == 0) target_buf.push_back(8'h2F);
  endtask

  // separators, escapes and hex digits mixed with random bytes
  task automatic build_noise_target();
    int len;
    target_buf.delete();
    len = $urandom_range(1, 8);
    repeat (len) begin
      case ($urandom_range(0, 9))
        0: target_buf.push_back(ChPercent);
        1: target_buf.push_back(ChQuestion);
        2: target_buf.push_back(ChEquals);
        3: target_buf.push_back(ChAmp);
        4: target_buf.push_back(hex_char(4'($urandom_range(0, 15))));
        default: target_buf.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic test_literals_and_escapes();
    byte_list_t t;
    // separators taken as literals outside their token, escaped '?' stays literal
    t = {8'h00, ChAmp, ChEquals, ChPercent, 8'h61, 8'h46, ChQuestion, ChPercent, 8'h33,
         8'h46, ChQuestion, ChEquals, ChEquals, 8'hFF};
    send_target(t);
  endtask

  task automatic test_trailing_separators();
    byte_list_t t;
    t = {ChQuestion, 8'h78, ChEquals, ChAmp};
    send_target(t);
    t = {ChQuestion};
    send_target(t);
  endtask

  task automatic test_bad_escapes();
    byte_list_t t;
    // bad second digit on a raw '?', bad first digit, then escape cut off by the end
    t = {ChPercent, 8'h30, ChQuestion, ChPercent, 8'h7A, ChPercent};
    send_target(t);
  endtask

  task automatic test_name_without_value();
    byte_list_t t;
    t = {ChQuestion, 8'h6E};
    send_target(t);
  endtask

  task automatic test_random_targets(input int n_bytes, input bit with_idling);
    int stop_at;
    idling_on = with_idling;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 99) < 75) build_good_target();
      else build_noise_target();
      send_target(target_buf);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_literals_and_escapes();
    test_trailing_separators();
    test_bad_escapes();
    test_name_without_value();
    test_random_targets(830, 1'b1);
    test_random_targets(250, 1'b0);
    test_random_targets(50, 1'b1);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (decoded_queue.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/uqd_pkg.sv
rtl/url_path_query_decoder.sv
test/testbench.sv
